>>> sv/prpd_pkg.sv
// shared types, codes and constants of the palette run-length pixel decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prpd_pkg;

  localparam int DEF_PALETTE_DEPTH = 256;

  // restoring divide of a 17-bit dividend, one quotient bit per cycle
  localparam int DIV_BITS  = 17;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // request codes
  localparam logic [1:0] REQ_PALETTE = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_START   = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_COLOUR = 2'd1;
  localparam logic [1:0] STS_PAST_END  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MAX_COLOUR  = 2'd0;
  localparam logic [1:0] REG_IMG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_IMG_HEIGHT  = 2'd2;

  localparam logic [7:0]  RST_MAX_COLOUR = 8'd255;
  localparam logic [15:0] RST_IMG_WIDTH  = 16'd1;
  localparam logic [15:0] RST_IMG_HEIGHT = 16'd1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  run_length;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic load_div;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_colour;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/prpd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module prpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/prpd_ctrl.sv
// sequencing state machine of the decoder
// depends on prpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module prpd_ctrl
  import prpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] req_type,
  input  wire dp_sts_t    sts,
  output logic            in_stall,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (req_type == REQ_DATA)) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = sts.no_colour ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_FETCH: begin
        cmd.load_div = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a coded byte always goes on to the palette fetch
  a_data_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && (req_type == REQ_DATA) |=> state_r == ST_FETCH)
    else $error("coded byte did not start a fetch");

endmodule

`default_nettype wire

>>> sv/prpd_dp.sv
// datapath: palette ram, raster position, serial divider, output register
// depends on prpd_pkg and prpd_ram
`timescale 1ns / 1ps
`default_nettype none

module prpd_dp
  import prpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire in_item_t    in_data,
  input  wire logic [7:0]  max_colour_id,
  input  wire logic [15:0] image_width,
  input  wire logic [15:0] image_height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  // palette
  logic          pal_we;
  logic          pal_re;
  logic [23:0]   pal_rdata;
  logic          wr_in_range;

  assign wr_in_range = {1'b0, in_data.palette_index} < 9'(PALETTE_DEPTH);
  assign pal_we = cmd.take && (in_data.req_type == REQ_PALETTE) && wr_in_range;
  assign pal_re = cmd.take && (in_data.req_type == REQ_DATA);

  prpd_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.palette_index[AW-1:0]),
    .wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
    .re    (pal_re),
    .raddr (in_data.data_byte[AW-1:0]),
    .rdata (pal_rdata)
  );

  // item and position state
  logic [23:0] colour_r, colour_nxt;
  logic        colour_valid_r, colour_valid_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic        is_colour_r, is_colour_nxt;
  logic        rd_in_range_r, rd_in_range_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        err_r, err_nxt;

  // divider
  logic [DIV_BITS-1:0]  acc_r, acc_nxt;
  logic [DIV_BITS-1:0]  dvd_r, dvd_nxt;
  logic [15:0]          divisor_r, divisor_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0]  trial;
  logic                 trial_ge;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // end-of-run arithmetic
  logic [17:0] row_sum;
  logic [17:0] last_row;
  logic        past_end;
  logic        byte_is_colour;

  assign byte_is_colour = in_data.data_byte <= max_colour_id;

  assign trial    = {acc_r[DIV_BITS-2:0], dvd_r[DIV_BITS-1]};
  assign trial_ge = trial >= {1'b0, divisor_r};

  // quotient counts rows crossed; the last pixel sits one row up when the run ends a row
  assign row_sum  = 18'(row_r) + 18'(dvd_r);
  assign last_row = row_sum - 18'(acc_r == '0);
  assign past_end = last_row >= 18'(image_height);

  assign sts.no_colour = !is_colour_r && !colour_valid_r;
  assign sts.div_last  = cnt_r == DIV_CNT_W'(DIV_BITS - 1);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    colour_nxt       = colour_r;
    colour_valid_nxt = colour_valid_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    is_colour_nxt    = is_colour_r;
    rd_in_range_nxt  = rd_in_range_r;
    len_nxt          = len_r;
    err_nxt          = err_r;
    acc_nxt          = acc_r;
    dvd_nxt          = dvd_r;
    divisor_nxt      = divisor_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    if (cmd.take) begin
      case (in_data.req_type)
        REQ_START: begin
          col_nxt          = '0;
          row_nxt          = '0;
          colour_nxt       = '0;
          colour_valid_nxt = 1'b0;
        end
        REQ_DATA: begin
          is_colour_nxt   = byte_is_colour;
          rd_in_range_nxt = {1'b0, in_data.data_byte} < 9'(PALETTE_DEPTH);
          len_nxt         = byte_is_colour ? 8'd1 : in_data.data_byte - max_colour_id;
        end
        default: begin
          // palette writes go straight to the ram, unknown codes are dropped
        end
      endcase
    end

    if (cmd.load_div) begin
      err_nxt = sts.no_colour;
      if (is_colour_r) begin
        colour_nxt       = rd_in_range_r ? pal_rdata : 24'd0;
        colour_valid_nxt = 1'b1;
      end
      acc_nxt     = '0;
      dvd_nxt     = DIV_BITS'(col_r) + DIV_BITS'(len_r);
      divisor_nxt = (image_width == 16'd0) ? 16'd1 : image_width;
      cnt_nxt     = '0;
    end

    if (cmd.div_step) begin
      acc_nxt = trial_ge ? trial - {1'b0, divisor_r} : trial;
      dvd_nxt = {dvd_r[DIV_BITS-2:0], trial_ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
    end

    if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.run_length = len_r;
      out_data_nxt.start_x    = col_r;
      out_data_nxt.start_y    = row_r;
      if (err_r) begin
        out_data_nxt.red_out   = 8'd0;
        out_data_nxt.green_out = 8'd0;
        out_data_nxt.blue_out  = 8'd0;
        out_data_nxt.status    = STS_NO_COLOUR;
      end else begin
        out_data_nxt.red_out   = colour_r[23:16];
        out_data_nxt.green_out = colour_r[15:8];
        out_data_nxt.blue_out  = colour_r[7:0];
        out_data_nxt.status    = past_end ? STS_PAST_END : STS_OK;
        col_nxt                = acc_r[15:0];
        row_nxt                = (row_sum > 18'hffff) ? 16'hffff : row_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r       <= '0;
      colour_valid_r <= 1'b0;
      col_r          <= '0;
      row_r          <= '0;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
    end else begin
      colour_r       <= colour_nxt;
      colour_valid_r <= colour_valid_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      out_valid_r    <= out_valid_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_colour_r   <= is_colour_nxt;
    rd_in_range_r <= rd_in_range_nxt;
    len_r         <= len_nxt;
    err_r         <= err_nxt;
    acc_r         <= acc_nxt;
    dvd_r         <= dvd_nxt;
    divisor_r     <= divisor_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result is never written over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a stalled beat");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("loaded result not presented");

  // the remainder after a full divide is a legal column
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !err_r |-> acc_r < {1'b0, divisor_r})
    else $error("divider remainder not below width");

endmodule

`default_nettype wire

>>> sv/palette_rle_pixel_decoder.sv
// top level of the palette run-length pixel decoder: config registers and wiring
// depends on prpd_pkg, prpd_ctrl, prpd_dp (and prpd_ram below it)
//
// usage
//   input beats (in_valid / in_stall, payload in_data) carry a palette write,
//   a start-of-image request or one coded byte. a beat is taken on a rising
//   edge with in_valid high and in_stall low.
//   palette writes and start requests give no result.
//   a coded byte goes from acceptance to the result register in steps:
//   accept and issue the palette read, take the read data, run the
//   bit-serial divide of (column + run) by the image width that gives the
//   wrapped column and the rows crossed, then form and load the result.
//   a run byte with no current colour skips the divide. result beats leave
//   on out_valid / out_stall from an output register; the next item is taken
//   while a result still waits, and a stalled receiver holds the block only
//   when a second result is ready to load. the registers (max colour id,
//   width, height) sit on an apb-style port at byte addresses 0, 4, 8; the
//   user must write them only while the block is idle, which the block does
//   not enforce. synchronous reset clears position, current colour and the
//   output register; palette contents are undefined until software loads them.
`timescale 1ns / 1ps
`default_nettype none

module palette_rle_pixel_decoder
  import prpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [7:0]  max_colour_r, max_colour_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    max_colour_nxt = max_colour_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_COLOUR: max_colour_nxt = pwdata[7:0];
        REG_IMG_WIDTH:  width_nxt      = pwdata[15:0];
        REG_IMG_HEIGHT: height_nxt     = pwdata[15:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MAX_COLOUR: prdata = {24'd0, max_colour_r};
      REG_IMG_WIDTH:  prdata = {16'd0, width_r};
      REG_IMG_HEIGHT: prdata = {16'd0, height_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_colour_r <= RST_MAX_COLOUR;
      width_r      <= RST_IMG_WIDTH;
      height_r     <= RST_IMG_HEIGHT;
    end else begin
      max_colour_r <= max_colour_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
    end
  end

  // controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  prpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  prpd_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_data       (in_data),
    .max_colour_id (max_colour_r),
    .image_width   (width_r),
    .image_height  (height_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// self-checking bench for the palette run-length pixel decoder
// depends on prpd_pkg and the palette_rle_pixel_decoder rtl
`timescale 1ns / 1ps

module tb_top;
  import prpd_pkg::*;

  // the one request code that the package leaves unnamed, ignored by the block
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  // settling allowance after the last run is out, before touching registers
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned MAX_REPORTS  = 40;

  // scoreboard: mirrors the decoder state and holds the runs still to come out
  class run_scoreboard;
    logic [23:0] pal [DEF_PALETTE_DEPTH];
    logic [23:0] run_colour;
    bit          have_colour;
    int unsigned cur_col;
    int unsigned cur_row;
    logic [7:0]  max_index;
    logic [15:0] img_w;
    logic [15:0] img_h;
    out_item_t   runs_due[$];
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_err;

    function new();
      foreach (pal[i]) pal[i] = '0;
      run_colour  = '0;
      have_colour = 1'b0;
      cur_col     = 0;
      cur_row     = 0;
      max_index   = RST_MAX_COLOUR;
      img_w       = RST_IMG_WIDTH;
      img_h       = RST_IMG_HEIGHT;
      n_in        = 0;
      n_out       = 0;
      n_err       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MAX_COLOUR: max_index = val[7:0];
        REG_IMG_WIDTH:  img_w     = val[15:0];
        REG_IMG_HEIGHT: img_h     = val[15:0];
        default: ;
      endcase
    endfunction

    function bit drained();
      return runs_due.size() == 0;
    endfunction

    // append a run to the tail of the expected list
    function void queue_run(out_item_t r);
      runs_due.insert(runs_due.size(), r);
    endfunction

    // work out the run (if any) that an accepted input beat gives
    function void note_beat(in_item_t it);
      out_item_t   r;
      int unsigned len;
      int unsigned w;
      int unsigned last_row;
      int unsigned p;
      int unsigned y;
      n_in++;
      case (it.req_type)
        REQ_PALETTE: begin
          if (it.palette_index < DEF_PALETTE_DEPTH)
            pal[it.palette_index] = {it.red_in, it.green_in, it.blue_in};
        end
        REQ_START: begin
          cur_col     = 0;
          cur_row     = 0;
          have_colour = 1'b0;
          run_colour  = '0;
        end
        REQ_DATA: begin
          r = '0;
          r.start_x = cur_col[15:0];
          r.start_y = cur_row[15:0];
          if (it.data_byte <= max_index) begin
            run_colour  = (it.data_byte < DEF_PALETTE_DEPTH) ? pal[it.data_byte] : 24'd0;
            have_colour = 1'b1;
            len = 1;
          end else begin
            len = it.data_byte - max_index;
            if (!have_colour) begin
              // run with nothing to extend: black, position stays put
              r.run_length = len[7:0];
              r.status     = STS_NO_COLOUR;
              queue_run(r);
              return;
            end
          end
          w = (img_w == 16'd0) ? 1 : img_w;
          last_row = cur_row + (cur_col + len - 1) / w;
          r.status = (last_row >= img_h) ? STS_PAST_END : STS_OK;
          {r.red_out, r.green_out, r.blue_out} = run_colour;
          r.run_length = len[7:0];
          queue_run(r);
          p = cur_col + len;
          y = cur_row + p / w;
          cur_col = p % w;
          cur_row = (y > 32'hFFFF) ? 32'hFFFF : y;
        end
        default: ;
      endcase
    endfunction

    task automatic report_mismatch(string msg);
      n_err++;
      if (n_err <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report_mismatch($sformatf("run %0d %s got 0x%0h expected 0x%0h",
                                  n_out, what, got, want));
    endtask

    task automatic check_run(out_item_t got);
      out_item_t want;
      if (runs_due.size() == 0) begin
        report_mismatch($sformatf("unexpected run 0x%0h", got));
        return;
      end
      want = runs_due.pop_front();
      check_field("red", got.red_out, want.red_out);
      check_field("green", got.green_out, want.green_out);
      check_field("blue", got.blue_out, want.blue_out);
      check_field("run_length", got.run_length, want.run_length);
      check_field("start_x", got.start_x, want.start_x);
      check_field("start_y", got.start_y, want.start_y);
      check_field("status", got.status, want.status);
      n_out++;
    endtask
  endclass

  // clock, reset and every block input start at known values
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  run_scoreboard sb;

  // palette entries loaded so far; only these may be selected by a colour byte
  bit pal_loaded [DEF_PALETTE_DEPTH];

  // idling knobs set per phase by the stimulus process
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  bit          hold_wanted = 1'b0;

  // receiver-side counters, owned by the receiver process
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  palette_rle_pixel_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // receiver: check each result beat, then decide next cycle's stall
  // signals read here are the values from before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_run(out_data);
    if (hold_wanted && !hold_done) begin
      // long hold-off so the output register and then the input back up
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      // start a stall burst of random length, this stall included
      stall_left = $urandom_range(5, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic in_item_t beat(logic [1:0] req, logic [7:0] byte_val,
                                    logic [7:0] idx, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it.req_type      = req;
    it.data_byte     = byte_val;
    it.palette_index = idx;
    it.red_in        = r;
    it.green_in      = g;
    it.blue_in       = b;
    return it;
  endfunction

  // offer one beat and hold it until taken; valid stays high afterwards
  task automatic send_beat(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.req_type == REQ_PALETTE) pal_loaded[it.palette_index] = 1'b1;
    sb.note_beat(it);
  endtask

  task automatic sender_gap(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // setup phase, access phase, then an idle phase with the port released
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_regs(logic [7:0] max_id, logic [15:0] w, logic [15:0] h);
    reg_write(REG_MAX_COLOUR, {24'd0, max_id});
    reg_write(REG_IMG_WIDTH, {16'd0, w});
    reg_write(REG_IMG_HEIGHT, {16'd0, h});
  endtask

  // registers may only change once every run is out and the last beat has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (!sb.drained()) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly coded bytes with random content; colour bytes only pick loaded
  // entries, an unloaded pick becomes a palette load of that entry instead
  function automatic in_item_t pick_beat(int unsigned start_pct, int unsigned run_pct,
                                         int unsigned top_pct);
    in_item_t    it;
    logic [63:0] noise;
    int unsigned roll;
    int unsigned idx;
    int unsigned rb;
    noise = {$urandom, $urandom};
    it    = noise[41:0];
    roll  = $urandom_range(99);
    if (roll < 4) begin
      it.req_type = REQ_UNKNOWN;
    end else if (roll < 4 + start_pct) begin
      it.req_type = REQ_START;
    end else if (roll < 16 + start_pct) begin
      it.req_type = REQ_PALETTE;
    end else begin
      it.req_type = REQ_DATA;
      if (sb.max_index != 8'hFF && $urandom_range(99) < run_pct) begin
        if ($urandom_range(99) < top_pct) rb = 255;
        else rb = $urandom_range(255, sb.max_index + 1);
        it.data_byte = rb[7:0];
      end else begin
        idx = $urandom_range(sb.max_index, 0);
        if (pal_loaded[idx]) begin
          it.data_byte = idx[7:0];
        end else begin
          it.req_type      = REQ_PALETTE;
          it.palette_index = idx[7:0];
        end
      end
    end
    return it;
  endfunction

  // ignored beats do not count toward the phase length
  task automatic run_phase(int unsigned beats, int unsigned start_pct,
                           int unsigned run_pct, int unsigned top_pct);
    in_item_t    it;
    int unsigned done;
    done = 0;
    while (done < beats) begin
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) sender_gap($urandom_range(5, 1));
      it = pick_beat(start_pct, run_pct, top_pct);
      send_beat(it);
      if (it.req_type != REQ_UNKNOWN) done++;
    end
  endtask

  initial begin
    sb = new();
    foreach (pal_loaded[i]) pal_loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset settings: every colour index is a colour, 1x1 image
    send_beat(beat(REQ_PALETTE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_beat(beat(REQ_PALETTE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_PALETTE, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55));
    send_beat(beat(REQ_PALETTE, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA));
    send_beat(beat(REQ_UNKNOWN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_beat(beat(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // second pixel of a one-row image lands past the end
    send_beat(beat(REQ_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();

    // directed, 3x2 image with run bytes above 0xa9
    set_regs(8'hA9, 16'd3, 16'd2);
    send_beat(beat(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // run bytes before any colour after a start
    send_beat(beat(REQ_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00));
    // long run wraps many rows and falls past the end
    send_beat(beat(REQ_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // reloading the entry must not change the colour already selected
    send_beat(beat(REQ_PALETTE, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56));
    send_beat(beat(REQ_DATA, 8'hAB, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(REQ_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_drained();

    // mixed traffic with idling on both sides and one long receiver hold
    set_regs(8'd127, 16'd17, 16'd9);
    gap_pct   = 25;
    stall_pct = 20;
    run_phase(20, 6, 45, 0);
    hold_wanted = 1'b1;
    run_phase(100, 6, 45, 0);
    wait_drained();

    // zero width acts as one; long runs drive the row count into saturation
    set_regs(8'd0, 16'd0, 16'd65535);
    gap_pct   = 15;
    stall_pct = 15;
    while (sb.cur_row < 32'hFFFF) run_phase(1, 0, 95, 85);
    run_phase(12, 0, 95, 85);
    wait_drained();

    // every byte a colour, widest row; sender never idles
    set_regs(8'd255, 16'd65535, 16'd1);
    gap_pct   = 0;
    stall_pct = 30;
    run_phase(60, 0, 0, 0);
    wait_drained();

    // narrow width below the current column, zero height flags everything
    set_regs(8'd200, 16'd5, 16'd0);
    gap_pct   = 30;
    stall_pct = 0;
    run_phase(60, 5, 50, 0);
    wait_drained();

    // closing stretch at full rate, no idling either side
    set_regs(8'd63, 16'd640, 16'd480);
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(80, 4, 50, 20);
    wait_drained();

    $display("covered %0d input beats and %0d runs over seven register settings",
             sb.n_in, sb.n_out);
    $display("incl. long receiver hold, zero width and height, row saturation, colourless runs");
    if (sb.n_err == 0 && sb.drained()) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
